### design/jzd_pkg.sv
// Package with shared types, register indexes and constants of the joystick zone dash detector.
`default_nettype none
package jzd_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TickW   = 8;
  localparam int unsigned MsW     = 13;
  localparam int unsigned TimerW  = 14;
  localparam int unsigned RawLvlW = 3;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 13;

  localparam logic [RawLvlW-1:0] LvlNone   = 3'd0;
  localparam logic [RawLvlW-1:0] LvlWeak   = 3'd1;
  localparam logic [RawLvlW-1:0] LvlMid    = 3'd3;
  localparam logic [RawLvlW-1:0] LvlStrong = 3'd5;

  localparam logic [4:0] StrongSum = 5'd4;
  localparam logic [TimerW-1:0] TimerMax = 14'd8445;

  localparam logic [CfgIdxW-1:0] RegDeadZone  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEdgeZone  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMidZone   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTickMs    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTimeLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDashMax   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDashMin   = 3'd6;

  typedef struct packed {
    logic [SampleW-1:0] dead_zone;
    logic [SampleW-1:0] edge_zone;
    logic [SampleW-1:0] mid_zone;
    logic [TickW-1:0]   tick_ms;
    logic [MsW-1:0]     time_limit;
    logic [MsW-1:0]     dash_max_ms;
    logic [MsW-1:0]     dash_min_ms;
  } cfg_t;

  typedef struct packed {
    logic [RawLvlW-1:0] lo;
    logic [RawLvlW-1:0] hi;
  } axis_lvl_t;

endpackage
`default_nettype wire

### design/jzd_if.sv
// Channel interfaces for samples, levels and register writes.
`default_nettype none
interface jzd_sample_if;
  logic                      valid;
  logic                      ready;
  logic [jzd_pkg::SampleW-1:0] supply_sample;
  logic [jzd_pkg::SampleW-1:0] x_sample;
  logic [jzd_pkg::SampleW-1:0] y_sample;
  modport source (output valid, supply_sample, x_sample, y_sample, input ready);
  modport sink (input valid, supply_sample, x_sample, y_sample, output ready);
endinterface

interface jzd_level_if;
  logic                       valid;
  logic                       ready;
  logic [jzd_pkg::LevelW-1:0] left_level;
  logic [jzd_pkg::LevelW-1:0] right_level;
  logic [jzd_pkg::LevelW-1:0] down_level;
  logic [jzd_pkg::LevelW-1:0] up_level;
  modport source (output valid, left_level, right_level, down_level, up_level, input ready);
  modport sink (input valid, left_level, right_level, down_level, up_level, output ready);
endinterface

interface jzd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [jzd_pkg::CfgIdxW-1:0] index;
  logic [jzd_pkg::CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/joystick_zone_dash_detector.sv
// Top level of the joystick zone dash detector: register file, two axis lanes and merge stage.
// Usage:
// The sample channel takes one item holding the supply, X and Y readings. The
// level channel returns one item per sample with left, right, down and up levels.
// The cfg channel writes register index 0..6 (dead zone, edge zone, mid zone,
// tick length, time limit, dash maximum, dash minimum); other indexes are ignored.
// It is always ready and should be used only while no item is in flight.
// The lane register and then the output register lie between an accepted sample
// and its result on the level channel.
// Throughput is one item per cycle while the receiver takes results; the X and Y
// lanes run side by side in the first stage.
// When the receiver stalls, the output register holds its item and the lane
// stage can still take one more sample before ready drops.
// A synchronous reset empties both stages, clears both timers and the dash
// latch, and loads the register defaults.
`default_nettype none
module joystick_zone_dash_detector (
  input  wire logic   clk,
  input  wire logic   rst,
  jzd_sample_if.sink  sample,
  jzd_level_if.source level,
  jzd_cfg_if.sink     cfg
);
  import jzd_pkg::*;

  cfg_t      regs;
  logic      s1_valid;
  logic      s1_en;
  logic      adv;
  axis_lvl_t x_lvl;
  axis_lvl_t y_lvl;

  assign cfg.ready    = 1'b1;
  assign s1_en        = !s1_valid || adv;
  assign sample.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dead_zone   <= 10'd100;
      regs.edge_zone   <= 10'd7;
      regs.mid_zone    <= 10'd200;
      regs.tick_ms     <= 8'd12;
      regs.time_limit  <= 13'd4028;
      regs.dash_max_ms <= 13'd300;
      regs.dash_min_ms <= 13'd10;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegDeadZone:  regs.dead_zone   <= cfg.data[SampleW-1:0];
        RegEdgeZone:  regs.edge_zone   <= cfg.data[SampleW-1:0];
        RegMidZone:   regs.mid_zone    <= cfg.data[SampleW-1:0];
        RegTickMs:    regs.tick_ms     <= cfg.data[TickW-1:0];
        RegTimeLimit: regs.time_limit  <= cfg.data[MsW-1:0];
        RegDashMax:   regs.dash_max_ms <= cfg.data[MsW-1:0];
        RegDashMin:   regs.dash_min_ms <= cfg.data[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= sample.valid;
    end
  end

  jzd_lane u_lane_x (
    .clk    (clk),
    .en     (s1_en && sample.valid),
    .cfg    (regs),
    .supply (sample.supply_sample),
    .s      (sample.x_sample),
    .lvl    (x_lvl)
  );

  jzd_lane u_lane_y (
    .clk    (clk),
    .en     (s1_en && sample.valid),
    .cfg    (regs),
    .supply (sample.supply_sample),
    .s      (sample.y_sample),
    .lvl    (y_lvl)
  );

  jzd_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .in_valid    (s1_valid),
    .x_lvl       (x_lvl),
    .y_lvl       (y_lvl),
    .adv         (adv),
    .out_valid   (level.valid),
    .out_ready   (level.ready),
    .left_level  (level.left_level),
    .right_level (level.right_level),
    .down_level  (level.down_level),
    .up_level    (level.up_level)
  );

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(x_lvl) && $stable(y_lvl))
    else $error("Lane stage lost an item while the merge stage was stalled.");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> sample.ready)
    else $error("Sample channel stalled with an empty lane stage.");
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv |=> level.valid)
    else $error("Merged item did not reach the output register.");
`endif
endmodule
`default_nettype wire

### design/jzd_lane.sv
// One axis lane: splits a sample into registered low and high side levels.
`default_nettype none
module jzd_lane (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire jzd_pkg::cfg_t               cfg,
  input  wire logic [jzd_pkg::SampleW-1:0] supply,
  input  wire logic [jzd_pkg::SampleW-1:0] s,
  output jzd_pkg::axis_lvl_t               lvl
);
  import jzd_pkg::*;

  logic [SampleW:0]   center;
  logic [SampleW:0]   s_w;
  logic [SampleW:0]   sup_w;
  axis_lvl_t          lvl_next;

  always_comb begin
    center = {2'b00, supply[SampleW-1:1]};
    s_w    = {1'b0, s};
    sup_w  = {1'b0, supply};
    if (s < cfg.edge_zone) begin
      lvl_next.lo = LvlStrong;
    end else if (s < cfg.mid_zone) begin
      lvl_next.lo = LvlMid;
    end else if (s_w + {1'b0, cfg.dead_zone} < center) begin
      lvl_next.lo = LvlWeak;
    end else begin
      lvl_next.lo = LvlNone;
    end
    if (sup_w < s_w + {1'b0, cfg.edge_zone}) begin
      lvl_next.hi = LvlStrong;
    end else if (sup_w < s_w + {1'b0, cfg.mid_zone}) begin
      lvl_next.hi = LvlMid;
    end else if (center + {1'b0, cfg.dead_zone} < s_w) begin
      lvl_next.hi = LvlWeak;
    end else begin
      lvl_next.hi = LvlNone;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lvl <= lvl_next;
    end
  end
endmodule
`default_nettype wire

### design/jzd_merge.sv
// Merge stage: timers, dash latch and the output register.
`default_nettype none
module jzd_merge (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire jzd_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  input  wire jzd_pkg::axis_lvl_t         x_lvl,
  input  wire jzd_pkg::axis_lvl_t         y_lvl,
  output logic                            adv,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [jzd_pkg::LevelW-1:0]      left_level,
  output logic [jzd_pkg::LevelW-1:0]      right_level,
  output logic [jzd_pkg::LevelW-1:0]      down_level,
  output logic [jzd_pkg::LevelW-1:0]      up_level
);
  import jzd_pkg::*;

  logic [TimerW-1:0] off_center_time;
  logic [TimerW-1:0] off_center_time_next;
  logic [TimerW-1:0] since_strong_time;
  logic [TimerW-1:0] since_strong_time_next;
  logic              dash;
  logic              dash_next;
  logic              strong_tick;
  logic [4:0]        sum;
  logic              take;
  logic [TimerW-1:0] limit_w;
  logic [TimerW-1:0] tick_w;
  logic [TimerW-1:0] max_w;
  logic [TimerW-1:0] min_w;

  assign adv  = !out_valid || out_ready;
  assign take = adv && in_valid;

  always_comb begin
    limit_w = {1'b0, cfg.time_limit};
    tick_w  = {{(TimerW-TickW){1'b0}}, cfg.tick_ms};
    max_w   = {1'b0, cfg.dash_max_ms};
    min_w   = {1'b0, cfg.dash_min_ms};
    sum = {2'b00, x_lvl.lo} + {2'b00, x_lvl.hi} + {2'b00, y_lvl.lo} + {2'b00, y_lvl.hi};
    strong_tick = sum >= StrongSum;
    if (x_lvl.lo == LvlNone && x_lvl.hi == LvlNone) begin
      off_center_time_next = '0;
    end else if (off_center_time < limit_w) begin
      off_center_time_next = off_center_time + tick_w;
    end else begin
      off_center_time_next = off_center_time;
    end
    if (strong_tick) begin
      dash_next = dash || (off_center_time_next < max_w && min_w < since_strong_time
                           && since_strong_time < max_w);
      since_strong_time_next = '0;
    end else begin
      dash_next = 1'b0;
      if (since_strong_time < limit_w) begin
        since_strong_time_next = since_strong_time + tick_w;
      end else begin
        since_strong_time_next = since_strong_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_center_time   <= '0;
      since_strong_time <= '0;
      dash              <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (take) begin
        off_center_time   <= off_center_time_next;
        since_strong_time <= since_strong_time_next;
        dash              <= dash_next;
      end
      if (adv) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (dash_next) begin
        left_level  <= {x_lvl.lo, 1'b0};
        right_level <= {x_lvl.hi, 1'b0};
        down_level  <= {y_lvl.lo, 1'b0};
        up_level    <= {y_lvl.hi, 1'b0};
      end else begin
        left_level  <= {1'b0, x_lvl.lo};
        right_level <= {1'b0, x_lvl.hi};
        down_level  <= {1'b0, y_lvl.lo};
        up_level    <= {1'b0, y_lvl.hi};
      end
    end
  end

`ifndef SYNTHESIS
  a_dash_clears_since: assert property (@(posedge clk) disable iff (rst)
    dash |-> since_strong_time == '0)
    else $error("Dash latch is set while the release timer is running.");
  a_dash_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && dash |-> !left_level[0] && !right_level[0] && !down_level[0] && !up_level[0])
    else $error("Dash result carries an undoubled level.");
  a_timer_bound: assert property (@(posedge clk) disable iff (rst)
    off_center_time <= TimerMax && since_strong_time <= TimerMax)
    else $error("Timer went past its saturation headroom.");
`endif
endmodule
`default_nettype wire
